[rtl/core/euler_rigid_transform_matrix_core_macros.svh]
// Assertion macros used by the checker file.
`ifndef EULER_RIGID_TRANSFORM_MATRIX_CORE_MACROS_SVH
`define EULER_RIGID_TRANSFORM_MATRIX_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ERM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ERM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/erm_pkg.sv]
package erm_pkg;

    typedef logic signed [31:0] trig_t;
    typedef logic signed [15:0] elem_t;
    typedef logic signed [31:0] pos_t;

    localparam int ATAN_ENTRIES = 24;
    localparam int LANE_W = 34;
    localparam int ANG_W = 36;

    localparam logic signed [LANE_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [ANG_W-1:0] PI_Q30 = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;

    localparam logic signed [15:0] ELEM_MAX = 16'sd16384;
    localparam logic signed [15:0] ELEM_MIN = -16'sd16384;

    function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0: v = 32'h3243F6A8;
            1: v = 32'h1DAC6705;
            2: v = 32'h0FADBAFC;
            3: v = 32'h07F56EA6;
            4: v = 32'h03FEAB76;
            5: v = 32'h01FFD55B;
            6: v = 32'h00FFFAAA;
            7: v = 32'h007FFF55;
            8: v = 32'h003FFFEA;
            9: v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return $signed({4'b0000, v});
    endfunction

    // Q2.30 product rounded to nearest, ties upward.
    function automatic trig_t mul30(input trig_t a, input trig_t b);
        logic signed [63:0] p;
        logic signed [63:0] r;
        p = a * b;
        r = (p + 64'sd536870912) >>> 30;
        return r[31:0];
    endfunction

    // Sum or difference of two Q2.30 values, rounded and clamped to Q2.14.
    function automatic elem_t q14(input trig_t a, input trig_t b, input logic sub);
        logic signed [33:0] ea;
        logic signed [33:0] eb;
        logic signed [33:0] s;
        logic signed [33:0] r;
        ea = {{2{a[31]}}, a};
        eb = {{2{b[31]}}, b};
        s = sub ? (ea - eb) : (ea + eb);
        r = (s + 34'sd32768) >>> 16;
        if (r > 34'sd16384)
            return ELEM_MAX;
        else if (r < -34'sd16384)
            return ELEM_MIN;
        else
            return r[15:0];
    endfunction

endpackage

[rtl/core/erm_cordic.sv]
module erm_cordic #(
    parameter int STEPS = 16
) (
    input  logic clk,
    input  logic en,
    input  logic signed [15:0] angle,
    output erm_pkg::trig_t cos_q30,
    output erm_pkg::trig_t sin_q30
);
    import erm_pkg::*;

    logic signed [LANE_W-1:0] x_reg [0:STEPS];
    logic signed [LANE_W-1:0] y_reg [0:STEPS];
    logic signed [ANG_W-1:0] z_reg [0:STEPS];
    logic neg_reg [0:STEPS];

    logic signed [ANG_W-1:0] z_in;
    logic signed [ANG_W-1:0] z0_next;
    logic neg0_next;
    logic signed [LANE_W-1:0] x_out;
    logic signed [LANE_W-1:0] y_out;

    assign z_in = {{(ANG_W-33){angle[15]}}, angle, 17'b0};

    // Angles beyond a quarter turn are folded by pi and the results negated.
    always_comb
    begin
        z0_next = z_in;
        neg0_next = 1'b0;
        if (z_in > HALF_PI_Q30)
        begin
            z0_next = z_in - PI_Q30;
            neg0_next = 1'b1;
        end
        else if (z_in < -HALF_PI_Q30)
        begin
            z0_next = z_in + PI_Q30;
            neg0_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= z0_next;
            neg_reg[0] <= neg0_next;
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[k+1] <= neg_reg[k];
                if (z_reg[k] >= 0)
                begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - atan_q30(k);
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + atan_q30(k);
                end
            end
        end
    end

    assign x_out = neg_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
    assign y_out = neg_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];
    assign cos_q30 = x_out[31:0];
    assign sin_q30 = y_out[31:0];

endmodule

[rtl/core/erm_mat.sv]
module erm_mat (
    input  logic clk,
    input  logic en,
    input  erm_pkg::trig_t cx,
    input  erm_pkg::trig_t sx,
    input  erm_pkg::trig_t cy,
    input  erm_pkg::trig_t sy,
    input  erm_pkg::trig_t cz,
    input  erm_pkg::trig_t sz,
    output erm_pkg::elem_t m [9]
);
    import erm_pkg::*;

    trig_t czcy_reg, szcy_reg, czsy_reg, szsy_reg, szcx_reg;
    trig_t czcx_reg, cysx_reg, szsx_reg, czsx_reg, cycx_reg;
    trig_t sx_reg, cx_reg, sy_reg;

    trig_t t3_reg, t4_reg, t6_reg, t7_reg;
    trig_t szcx2_reg, czcx2_reg, szsx2_reg, czsx2_reg;
    trig_t czcy2_reg, szcy2_reg, cysx2_reg, cycx2_reg, sy2_reg;

    elem_t m_reg [9];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            czcy_reg <= mul30(cz, cy);
            szcy_reg <= mul30(sz, cy);
            czsy_reg <= mul30(cz, sy);
            szsy_reg <= mul30(sz, sy);
            szcx_reg <= mul30(sz, cx);
            czcx_reg <= mul30(cz, cx);
            cysx_reg <= mul30(cy, sx);
            szsx_reg <= mul30(sz, sx);
            czsx_reg <= mul30(cz, sx);
            cycx_reg <= mul30(cy, cx);
            sx_reg <= sx;
            cx_reg <= cx;
            sy_reg <= sy;

            t3_reg <= mul30(czsy_reg, sx_reg);
            t4_reg <= mul30(szsy_reg, sx_reg);
            t6_reg <= mul30(czsy_reg, cx_reg);
            t7_reg <= mul30(szsy_reg, cx_reg);
            szcx2_reg <= szcx_reg;
            czcx2_reg <= czcx_reg;
            szsx2_reg <= szsx_reg;
            czsx2_reg <= czsx_reg;
            czcy2_reg <= czcy_reg;
            szcy2_reg <= szcy_reg;
            cysx2_reg <= cysx_reg;
            cycx2_reg <= cycx_reg;
            sy2_reg <= sy_reg;

            m_reg[0] <= q14(czcy2_reg, '0, 1'b0);
            m_reg[1] <= q14(szcy2_reg, '0, 1'b0);
            m_reg[2] <= q14('0, sy2_reg, 1'b1);
            m_reg[3] <= q14(t3_reg, szcx2_reg, 1'b1);
            m_reg[4] <= q14(t4_reg, czcx2_reg, 1'b0);
            m_reg[5] <= q14(cysx2_reg, '0, 1'b0);
            m_reg[6] <= q14(t6_reg, szsx2_reg, 1'b0);
            m_reg[7] <= q14(t7_reg, czsx2_reg, 1'b1);
            m_reg[8] <= q14(cycx2_reg, '0, 1'b0);
        end
    end

    assign m = m_reg;

endmodule

[rtl/core/erm_off.sv]
module erm_off (
    input  logic clk,
    input  logic en,
    input  erm_pkg::elem_t m_in [9],
    input  erm_pkg::pos_t ctr [3],
    input  erm_pkg::pos_t sh [3],
    output erm_pkg::elem_t m_out [9],
    output erm_pkg::pos_t off [3]
);
    import erm_pkg::*;

    localparam int ACC_W = 50;

    logic signed [48:0] prod_reg [9];
    logic signed [ACC_W-1:0] base_reg [3];
    logic signed [ACC_W-1:0] acc_reg [3];
    pos_t off_reg [3];
    elem_t m1_reg [9];
    elem_t m2_reg [9];
    elem_t m3_reg [9];

    function automatic pos_t sat32(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] r;
        r = (a + 50'sd8192) >>> 14;
        if (r > 50'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (r < -50'sd2147483648)
            return 32'sh80000000;
        else
            return r[31:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                base_reg[i] <= (ACC_W'(sh[i]) + ACC_W'(ctr[i])) <<< 14;
                for (int j = 0; j < 3; j++)
                    prod_reg[i*3+j] <= m_in[i*3+j] * ctr[j];
            end
            m1_reg <= m_in;

            for (int i = 0; i < 3; i++)
                acc_reg[i] <= base_reg[i]
                    - {prod_reg[i*3][48], prod_reg[i*3]}
                    - {prod_reg[i*3+1][48], prod_reg[i*3+1]}
                    - {prod_reg[i*3+2][48], prod_reg[i*3+2]};
            m2_reg <= m1_reg;

            for (int i = 0; i < 3; i++)
                off_reg[i] <= sat32(acc_reg[i]);
            m3_reg <= m2_reg;
        end
    end

    assign m_out = m3_reg;
    assign off = off_reg;

endmodule

[rtl/core/euler_rigid_transform_matrix_core.sv]
// Channel | Handshake             | Payload
// input   | in_valid / in_stall   | angle_x..z, center_x..z, shift_x..z
// output  | out_valid / out_stall | m00..m22, off_x..off_z
//
// One request enters per cycle unless the pipeline is stalled. Each request passes
// through the one-iteration-per-stage CORDIC lanes, then the matrix and offset pipes.
// Reset clears only the valid bits; there is no state between requests.
// A stalled result freezes the whole pipeline, so in_stall follows out_stall
// while a result is waiting.
module euler_rigid_transform_matrix_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic signed [15:0] angle_x,
    input  logic signed [15:0] angle_y,
    input  logic signed [15:0] angle_z,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic signed [31:0] shift_x,
    input  logic signed [31:0] shift_y,
    input  logic signed [31:0] shift_z,
    output logic out_valid,
    input  logic out_stall,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22,
    output logic signed [31:0] off_x,
    output logic signed [31:0] off_y,
    output logic signed [31:0] off_z
);
    import erm_pkg::*;

    localparam int NS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int POS_DLY = NS + 4;
    localparam int LAT = NS + 7;

    logic adv;
    logic [LAT-1:0] vld_reg;
    pos_t ctr_reg [POS_DLY][3];
    pos_t sh_reg [POS_DLY][3];

    trig_t cx, sx, cy, sy, cz, sz;
    elem_t m_mat [9];
    elem_t m_fin [9];
    pos_t off [3];

    assign adv = !(out_valid && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctr_reg[0][0] <= center_x;
            ctr_reg[0][1] <= center_y;
            ctr_reg[0][2] <= center_z;
            sh_reg[0][0] <= shift_x;
            sh_reg[0][1] <= shift_y;
            sh_reg[0][2] <= shift_z;
            for (int k = 1; k < POS_DLY; k++)
            begin
                ctr_reg[k] <= ctr_reg[k-1];
                sh_reg[k] <= sh_reg[k-1];
            end
        end
    end

    erm_cordic #(.STEPS(NS)) u_cordic_x (
        .clk(clk), .en(adv), .angle(angle_x), .cos_q30(cx), .sin_q30(sx)
    );
    erm_cordic #(.STEPS(NS)) u_cordic_y (
        .clk(clk), .en(adv), .angle(angle_y), .cos_q30(cy), .sin_q30(sy)
    );
    erm_cordic #(.STEPS(NS)) u_cordic_z (
        .clk(clk), .en(adv), .angle(angle_z), .cos_q30(cz), .sin_q30(sz)
    );

    erm_mat u_mat (
        .clk(clk), .en(adv),
        .cx(cx), .sx(sx), .cy(cy), .sy(sy), .cz(cz), .sz(sz),
        .m(m_mat)
    );

    erm_off u_off (
        .clk(clk), .en(adv),
        .m_in(m_mat), .ctr(ctr_reg[POS_DLY-1]), .sh(sh_reg[POS_DLY-1]),
        .m_out(m_fin), .off(off)
    );

    assign out_valid = vld_reg[LAT-1];
    assign m00 = m_fin[0];
    assign m01 = m_fin[1];
    assign m02 = m_fin[2];
    assign m10 = m_fin[3];
    assign m11 = m_fin[4];
    assign m12 = m_fin[5];
    assign m20 = m_fin[6];
    assign m21 = m_fin[7];
    assign m22 = m_fin[8];
    assign off_x = off[0];
    assign off_y = off[1];
    assign off_z = off[2];

endmodule

[rtl/core/erm_checker.sv]
`include "euler_rigid_transform_matrix_core_macros.svh"

module erm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic signed [15:0] m00,
    input logic signed [15:0] m11,
    input logic signed [31:0] off_x
);
    `ERM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
    `ERM_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(m00) && $stable(off_x), "stalled result changed")
    `ERM_ASSERT_NOW(a_backpressure, 1'b1, in_stall == (out_valid && out_stall), "input stall does not follow a waiting result")
    `ERM_ASSERT_NOW(a_elem_range, out_valid, m00 <= 16'sd16384 && m00 >= -16'sd16384 && m11 <= 16'sd16384 && m11 >= -16'sd16384, "element outside unit range")

endmodule

bind euler_rigid_transform_matrix_core erm_checker u_erm_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .m00(m00),
    .m11(m11),
    .off_x(off_x)
);
